[hdl/indexed_doubly_linked_list_unit_defines.svh]
// Assertion macros shared by the list unit checker.
// Depends on nothing; the user supplies clk and rst in scope.
`ifndef INDEXED_DOUBLY_LINKED_LIST_UNIT_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IDLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IDLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/idll_pkg.sv]
// Shared types and constants for the indexed doubly linked list unit.
// No dependencies.
package idll_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_INS_HEAD   = 3'd0,
    OP_INS_TAIL   = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_DELETE     = 3'd4,
    OP_FIND       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_HEAD,
    KIND_TAIL,
    KIND_AFTER
  } kind_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_FREE,
    RD_CUR
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POS_RD,
    S_POS_CHK,
    S_ALLOC,
    S_LINK1,
    S_LINK2,
    S_DEL1,
    S_DEL2,
    S_FIND_RD,
    S_FIND_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot_index;
    logic [3:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    pos_chk;
    logic    alloc;
    logic    link1;
    logic    link2;
    logic    del1;
    logic    del2;
    logic    find_chk;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic short_list;
    logic cnt_zero;
    logic pos_ok;
    logic is_delete;
    logic full;
    logic match;
    logic last;
  } sts_t;

endpackage

[hdl/idll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/idll_ctrl.sv]
// Sequencer for the list unit: walks each transaction through its steps.
// Depends on idll_pkg.
module idll_ctrl
  import idll_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (op inside {OP_INS_HEAD, OP_INS_TAIL}) begin
            state_next = S_ALLOC;
          end else if (op inside {OP_INS_AFTER, OP_INS_BEFORE}) begin
            state_next = sts.short_list ? S_ALLOC : S_POS_RD;
          end else if (op == OP_DELETE) begin
            state_next = S_POS_RD;
          end else if (op == OP_FIND) begin
            state_next = sts.cnt_zero ? S_DONE : S_FIND_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_POS_RD:   state_next = S_POS_CHK;
      S_POS_CHK: begin
        if (!sts.pos_ok)        state_next = S_DONE;
        else if (sts.is_delete) state_next = S_DEL1;
        else                    state_next = S_ALLOC;
      end
      S_ALLOC:    state_next = sts.full ? S_DONE : S_LINK1;
      S_LINK1:    state_next = S_LINK2;
      S_LINK2:    state_next = S_DONE;
      S_DEL1:     state_next = S_DEL2;
      S_DEL2:     state_next = S_DONE;
      S_FIND_RD:  state_next = S_FIND_CHK;
      S_FIND_CHK: state_next = (sts.match || sts.last) ? S_DONE : S_FIND_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_POS;
    busy     = (state != S_IDLE);
    done     = (state == S_DONE);
    case (state)
      S_CLEAR:    cmd.clear = 1'b1;
      S_IDLE:     cmd.load = start;
      S_POS_CHK:  cmd.pos_chk = 1'b1;
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        cmd.rd_sel = RD_FREE;
      end
      S_LINK1:    cmd.link1 = 1'b1;
      S_LINK2:    cmd.link2 = 1'b1;
      S_DEL1:     cmd.del1 = 1'b1;
      S_DEL2:     cmd.del2 = 1'b1;
      S_FIND_RD:  cmd.rd_sel = RD_CUR;
      S_FIND_CHK: cmd.find_chk = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

[hdl/idll_dpath.sv]
// Datapath for the list unit: link and value memories, list pointers, result.
// Depends on idll_pkg and idll_ram.
module idll_dpath
  import idll_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t result
);

  localparam int IW = $clog2(DEPTH);

  logic [2:0]            op_q;
  logic [3:0]            pos_q;
  logic [VALUE_BITS-1:0] val_q, val_ext;
  logic [IW-1:0]         head, tail, free_head, count;
  logic [IW-1:0]         cur, kcnt, s_slot, p_slot, pv_slot, nx_slot, slot_q, clr_idx;
  kind_t                 kind;
  status_t               st_q;

  logic [IW-1:0]         rd_addr, rd_next, rd_prev;
  logic                  rd_live;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  nx_we, pv_we, lv_we, val_we, lv_wd;
  logic [IW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd, lv_wa;

  logic [IW-1:0] pos_idx, one, cnt_m1;
  logic          pos_ok, cnt_zero, is_h, is_t;

  generate
    if (VALUE_BITS > 32) begin : g_ext
      assign val_ext = {{(VALUE_BITS-32){in_item.value[31]}}, in_item.value};
    end else begin : g_trunc
      assign val_ext = in_item.value[VALUE_BITS-1:0];
    end
  endgenerate

  assign one      = IW'(1);
  assign pos_idx  = IW'(pos_q);
  assign cnt_zero = (count == '0);
  assign cnt_m1   = count - one;
  assign pos_ok   = (pos_q != 4'd0) && ({28'd0, pos_q} < 32'(DEPTH)) && rd_live;
  assign is_h     = (p_slot == head);
  assign is_t     = (p_slot == tail);

  assign sts.clr_last   = (clr_idx == IW'(DEPTH - 1));
  assign sts.short_list = (count <= one);
  assign sts.cnt_zero   = cnt_zero;
  assign sts.pos_ok     = pos_ok;
  assign sts.is_delete  = (op_q == OP_DELETE);
  assign sts.full       = (free_head == '0);
  assign sts.match      = rd_live && (rd_value == val_q);
  assign sts.last       = (kcnt == cnt_m1);

  always_comb begin
    case (cmd.rd_sel)
      RD_FREE: rd_addr = free_head;
      RD_CUR:  rd_addr = cur;
      default: rd_addr = pos_idx;
    endcase
  end

  // Write port steering for the link memories.
  always_comb begin
    nx_we = 1'b0; nx_wa = s_slot; nx_wd = '0;
    pv_we = 1'b0; pv_wa = s_slot; pv_wd = '0;
    lv_we = 1'b0; lv_wa = s_slot; lv_wd = 1'b0;
    val_we = cmd.link1;
    if (cmd.clear) begin
      nx_we = 1'b1; nx_wa = clr_idx;
      nx_wd = (sts.clr_last || clr_idx == '0) ? '0 : clr_idx + one;
      pv_we = 1'b1; pv_wa = clr_idx;
      lv_we = 1'b1; lv_wa = clr_idx;
    end else if (cmd.link1) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      lv_we = 1'b1; lv_wd = 1'b1;
      case (kind)
        KIND_HEAD: nx_wd = cnt_zero ? '0 : head;
        KIND_TAIL: pv_wd = cnt_zero ? '0 : tail;
        default: begin
          nx_wd = nx_slot;
          pv_wd = p_slot;
        end
      endcase
    end else if (cmd.link2) begin
      nx_wd = s_slot;
      pv_wd = s_slot;
      case (kind)
        KIND_HEAD: begin
          pv_we = !cnt_zero; pv_wa = head;
        end
        KIND_TAIL: begin
          nx_we = !cnt_zero; nx_wa = tail;
        end
        default: begin
          nx_we = 1'b1; nx_wa = p_slot;
          pv_we = 1'b1; pv_wa = nx_slot;
        end
      endcase
    end else if (cmd.del1) begin
      nx_wa = pv_slot;
      pv_wa = nx_slot;
      if (is_h && !is_t) begin
        pv_we = 1'b1;
      end else if (is_t && !is_h) begin
        nx_we = 1'b1;
      end else if (!is_h && !is_t) begin
        nx_we = 1'b1; nx_wd = nx_slot;
        pv_we = 1'b1; pv_wd = pv_slot;
      end
    end else if (cmd.del2) begin
      nx_we = 1'b1; nx_wa = p_slot; nx_wd = free_head;
      pv_we = 1'b1; pv_wa = p_slot;
      lv_we = 1'b1; lv_wa = p_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= one;
      tail      <= one;
      free_head <= one;
      count     <= '0;
      clr_idx   <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + one;
      if (cmd.link1) free_head <= rd_next;
      if (cmd.link2) begin
        count <= count + one;
        case (kind)
          KIND_HEAD: begin
            head <= s_slot;
            if (cnt_zero) tail <= s_slot;
          end
          KIND_TAIL: begin
            tail <= s_slot;
            if (cnt_zero) head <= s_slot;
          end
          default: begin
          end
        endcase
      end
      if (cmd.del1) begin
        if (is_h && is_t) begin
          head <= one;
          tail <= one;
        end else if (is_h) begin
          head <= nx_slot;
        end else if (is_t) begin
          tail <= pv_slot;
        end
      end
      if (cmd.del2) begin
        free_head <= p_slot;
        count     <= cnt_m1;
      end
    end
  end

  // Transaction registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_item.op;
      pos_q  <= in_item.position;
      val_q  <= val_ext;
      cur    <= head;
      kcnt   <= '0;
      slot_q <= '0;
      st_q   <= (in_item.op == OP_FIND && cnt_zero) ? ST_NOTFOUND : ST_OK;
      kind   <= (in_item.op inside {OP_INS_HEAD, OP_INS_BEFORE}) ? KIND_HEAD : KIND_TAIL;
    end
    if (cmd.pos_chk) begin
      pv_slot <= rd_prev;
      if (!pos_ok) begin
        st_q <= ST_BADPOS;
      end else if (op_q == OP_INS_BEFORE) begin
        kind    <= (pos_idx == head) ? KIND_HEAD : KIND_AFTER;
        p_slot  <= rd_prev;
        nx_slot <= pos_idx;
      end else begin
        if (op_q == OP_INS_AFTER) kind <= (pos_idx == tail) ? KIND_TAIL : KIND_AFTER;
        p_slot  <= pos_idx;
        nx_slot <= rd_next;
      end
    end
    if (cmd.alloc) begin
      if (sts.full) st_q <= ST_FULL;
      s_slot <= free_head;
    end
    if (cmd.link2) slot_q <= s_slot;
    if (cmd.find_chk) begin
      if (sts.match) begin
        slot_q <= cur;
      end else begin
        cur  <= rd_next;
        kcnt <= kcnt + one;
        if (sts.last) st_q <= ST_NOTFOUND;
      end
    end
  end

  assign result.status      = st_q;
  assign result.slot_index  = 4'(slot_q);
  assign result.entry_count = 4'(count);

  idll_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(rd_next)
  );

  idll_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(rd_prev)
  );

  idll_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_live (
    .clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(rd_addr), .rdata(rd_live)
  );

  idll_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value (
    .clk(clk), .we(val_we), .waddr(s_slot), .wdata(val_q), .raddr(rd_addr), .rdata(rd_value)
  );

endmodule

[hdl/indexed_doubly_linked_list_unit.sv]
// Indexed doubly linked list unit: one transaction in flight, result strobed on done.
// An insert allocates a free slot and relinks it (after or before on a longer list checks
// its position first); a delete checks its position, then unlinks; a find compares each
// visited entry in turn. start is taken only while idle; the receiver cannot stall.
// Reset: synchronous rst starts a clearing pass over every slot that rebuilds the
// free chain; busy stays high until it ends.
module indexed_doubly_linked_list_unit
  import idll_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  // Command and status between sequencer and datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction: validate position, allocate or free a slot, relink, search, report.
  idll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (in_item.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the list in memories; result fields come straight from registers.
  idll_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule

[hdl/idll_checker.sv]
// Port-level checks for the list unit, bound to the top level.
// Depends on idll_pkg and indexed_doubly_linked_list_unit_defines.svh.
`include "indexed_doubly_linked_list_unit_defines.svh"
module idll_checker
  import idll_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_item_t result
);

  `IDLL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
  `IDLL_ASSERT_NOW(a_done_busy, done, busy, "result strobed while idle")
  `IDLL_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `IDLL_ASSERT_NOW(a_fail_slot, done && result.status != ST_OK, result.slot_index == 4'd0,
                   "failed transaction reports a slot")

endmodule

bind indexed_doubly_linked_list_unit idll_checker u_chk (.*);
